/* sv/bfsp_pkg.sv */
`timescale 1ns / 1ps

package bfsp_pkg;

   // sizing of the graph stores
   localparam int MAX_NODES = 64;
   localparam int MAX_EDGES = 256;

   localparam int NODE_AW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int EDGE_AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int COUNT_W  = $clog2(MAX_EDGES + 1);

   // fixed field widths
   localparam int NODE_W   = 6;
   localparam int NC_W     = 7;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 32;

   localparam logic [NC_W-1:0]    NC_MAX   = NC_W'(MAX_NODES);
   localparam logic [NC_W-1:0]    NC_RESET = NC_W'(64);
   localparam logic [COUNT_W-1:0] EDGE_CAP = COUNT_W'(MAX_EDGES);

   localparam logic signed [DIST_W-1:0] INT_MAX = 32'sh7fff_ffff;
   localparam logic signed [DIST_W-1:0] INT_MIN = 32'sh8000_0000;

   // action codes
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_RUN  = 1'b1;

   // one stored edge
   typedef struct packed {
      logic [NODE_W-1:0]          src;
      logic [NODE_W-1:0]          dst;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_type;

   localparam int EDGE_W = $bits(edge_type);

   // sequencer states
   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_EREAD = 7'b0000010,
      S_DREAD = 7'b0000100,
      S_CALC  = 7'b0001000,
      S_UPD   = 7'b0010000,
      S_OREAD = 7'b0100000,
      S_OEMIT = 7'b1000000
   } state_type;

endpackage

/* sv/bfsp_ram.sv */
`timescale 1ns / 1ps

module bfsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds until next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bellman_ford_shortest_paths.sv */
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// request   in         start & !busy          req_action, req_edge_from/to/weight
// response  out        rsp_valid, one cycle   rsp_node, rsp_distance, rsp_reachable,
//                                             rsp_negative_cycle, rsp_edges_dropped, rsp_last
// csr       in         csr_valid & csr_ready  csr_node_count
//
// an edge load is written to the edge store from the idle state; loads may be issued back to back
// a run takes (n-1) relax passes plus one check pass; per edge the sequencer steps EREAD, DREAD,
// CALC, UPD for the read-modify-write of the distance memory; then OREAD, OEMIT per node
// synchronous reset clears counters, flags and the sequencer, not the memories
// busy is high for the whole run; results cannot be stalled by the receiver

module bellman_ford_shortest_paths (
   input  logic                               clock,
   input  logic                               reset,
   // request
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [bfsp_pkg::NODE_W-1:0]        req_edge_from,
   input  logic [bfsp_pkg::NODE_W-1:0]        req_edge_to,
   input  logic signed [bfsp_pkg::WEIGHT_W-1:0] req_edge_weight,
   // response
   output logic                               rsp_valid,
   output logic [bfsp_pkg::NODE_W-1:0]        rsp_node,
   output logic signed [bfsp_pkg::DIST_W-1:0] rsp_distance,
   output logic                               rsp_reachable,
   output logic                               rsp_negative_cycle,
   output logic                               rsp_edges_dropped,
   output logic                               rsp_last,
   // csr
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bfsp_pkg::NC_W-1:0]          csr_node_count
);

   localparam int NODE_AW = bfsp_pkg::NODE_AW;
   localparam int EDGE_AW = bfsp_pkg::EDGE_AW;
   localparam int COUNT_W = bfsp_pkg::COUNT_W;
   localparam int NC_W    = bfsp_pkg::NC_W;
   localparam int DIST_W  = bfsp_pkg::DIST_W;
   localparam int EDGE_W  = bfsp_pkg::EDGE_W;

   // control state
   bfsp_pkg::state_type state_ff, state_in;
   logic [COUNT_W-1:0]  edge_count_ff, edge_count_in;
   logic [COUNT_W-1:0]  k_ff, k_in;
   logic [NC_W-1:0]     pass_ff, pass_in;
   logic                check_ff, check_in;
   logic                dropped_ff, dropped_in;
   logic [NC_W-1:0]     node_count_ff, node_count_in;
   logic [NC_W-1:0]     out_idx_ff, out_idx_in;
   logic [bfsp_pkg::MAX_NODES-1:0] reached_ff, reached_in;

   // datapath registers
   logic signed [DIST_W-1:0] cand_ff, cand_in;

   // result registers
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [bfsp_pkg::NODE_W-1:0] rsp_node_ff, rsp_node_in;
   logic signed [DIST_W-1:0] rsp_distance_ff, rsp_distance_in;
   logic                     rsp_reachable_ff, rsp_reachable_in;
   logic                     rsp_cycle_ff, rsp_cycle_in;
   logic                     rsp_dropped_ff, rsp_dropped_in;
   logic                     rsp_last_ff, rsp_last_in;

   // memory ports
   logic                 edge_wr_en, edge_rd_en;
   logic [EDGE_AW-1:0]   edge_wr_addr, edge_rd_addr;
   logic [EDGE_W-1:0]    edge_wr_data, edge_rd_data;
   logic                 dist_wr_en, dist_rd_en;
   logic [NODE_AW-1:0]   dist_wr_addr, dist_a_addr, dist_b_addr;
   logic [DIST_W-1:0]    dist_wr_data, dist_a_data, dist_b_data;

   bfsp_pkg::edge_type   edge_q, edge_new;
   logic [NC_W-1:0]      n_eff;
   logic signed [DIST_W-1:0] dist_a, dist_b;
   logic signed [DIST_W:0]   sum_wide;
   logic                 src_ok, dst_ok, relax_ok;
   logic [NC_W:0]        pass_next;

   assign edge_q = bfsp_pkg::edge_type'(edge_rd_data);
   assign dist_a = $signed(dist_a_data);
   assign dist_b = $signed(dist_b_data);

   // edge store: source, destination and weight of each loaded edge
   bfsp_ram #(.WIDTH(EDGE_W), .DEPTH(bfsp_pkg::MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_wr_en),
      .wr_addr (edge_wr_addr),
      .wr_data (edge_wr_data),
      .rd_en   (edge_rd_en),
      .rd_addr (edge_rd_addr),
      .rd_data (edge_rd_data)
   );

   // distance store, two copies for source and destination reads
   bfsp_ram #(.WIDTH(DIST_W), .DEPTH(bfsp_pkg::MAX_NODES)) u_dist_a_ram (
      .clock   (clock),
      .wr_en   (dist_wr_en),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_en   (dist_rd_en),
      .rd_addr (dist_a_addr),
      .rd_data (dist_a_data)
   );

   bfsp_ram #(.WIDTH(DIST_W), .DEPTH(bfsp_pkg::MAX_NODES)) u_dist_b_ram (
      .clock   (clock),
      .wr_en   (dist_wr_en),
      .wr_addr (dist_wr_addr),
      .wr_data (dist_wr_data),
      .rd_en   (dist_rd_en),
      .rd_addr (dist_b_addr),
      .rd_data (dist_b_data)
   );

   // clamp node count to the usable range
   always_comb begin
      if (node_count_ff == '0) begin
         n_eff = NC_W'(1);
      end else if (node_count_ff > bfsp_pkg::NC_MAX) begin
         n_eff = bfsp_pkg::NC_MAX;
      end else begin
         n_eff = node_count_ff;
      end
   end

   // relaxation test on the edge held in the edge read register
   assign src_ok    = {1'b0, edge_q.src} < n_eff;
   assign dst_ok    = {1'b0, edge_q.dst} < n_eff;
   assign relax_ok  = src_ok && dst_ok && reached_ff[edge_q.src[NODE_AW-1:0]] &&
                      (!reached_ff[edge_q.dst[NODE_AW-1:0]] || (cand_ff < dist_b));
   assign sum_wide  = {dist_a[DIST_W-1], dist_a} +
                      {{(DIST_W + 1 - bfsp_pkg::WEIGHT_W){edge_q.weight[bfsp_pkg::WEIGHT_W-1]}},
                       edge_q.weight};
   assign pass_next = {1'b0, pass_ff} + (NC_W + 1)'(2);

   assign edge_new.src    = req_edge_from;
   assign edge_new.dst    = req_edge_to;
   assign edge_new.weight = req_edge_weight;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      edge_count_in = edge_count_ff;
      k_in          = k_ff;
      pass_in       = pass_ff;
      check_in      = check_ff;
      dropped_in    = dropped_ff;
      out_idx_in    = out_idx_ff;
      reached_in    = reached_ff;
      cand_in       = cand_ff;
      node_count_in = node_count_ff;

      rsp_valid_in     = 1'b0;
      rsp_node_in      = rsp_node_ff;
      rsp_distance_in  = rsp_distance_ff;
      rsp_reachable_in = rsp_reachable_ff;
      rsp_cycle_in     = rsp_cycle_ff;
      rsp_dropped_in   = rsp_dropped_ff;
      rsp_last_in      = rsp_last_ff;

      edge_wr_en   = 1'b0;
      edge_wr_addr = edge_count_ff[EDGE_AW-1:0];
      edge_wr_data = edge_new;
      edge_rd_en   = 1'b0;
      edge_rd_addr = k_ff[EDGE_AW-1:0];
      dist_wr_en   = 1'b0;
      dist_wr_addr = edge_q.dst[NODE_AW-1:0];
      dist_wr_data = cand_ff;
      dist_rd_en   = 1'b0;
      dist_a_addr  = edge_q.src[NODE_AW-1:0];
      dist_b_addr  = edge_q.dst[NODE_AW-1:0];

      // csr transaction
      if (csr_valid) begin
         node_count_in = csr_node_count;
      end

      case (state_ff)
         bfsp_pkg::S_IDLE: begin
            if (start) begin
               if (req_action == bfsp_pkg::ACT_LOAD) begin
                  // store the edge unless full or out of range
                  if (edge_count_ff == bfsp_pkg::EDGE_CAP ||
                      {1'b0, req_edge_from} >= n_eff || {1'b0, req_edge_to} >= n_eff) begin
                     dropped_in = 1'b1;
                  end else begin
                     edge_wr_en    = 1'b1;
                     edge_count_in = edge_count_ff + COUNT_W'(1);
                  end
               end else begin
                  // run: source at distance 0, everything else unreached
                  dist_wr_en    = 1'b1;
                  dist_wr_addr  = '0;
                  dist_wr_data  = '0;
                  reached_in    = '0;
                  reached_in[0] = 1'b1;
                  k_in          = '0;
                  pass_in       = '0;
                  check_in      = (n_eff == NC_W'(1));
                  state_in      = bfsp_pkg::S_EREAD;
               end
            end
         end

         bfsp_pkg::S_EREAD: begin
            if (k_ff == edge_count_ff) begin
               // end of a pass
               k_in = '0;
               if (!check_ff) begin
                  if (pass_next < {1'b0, n_eff}) begin
                     pass_in = pass_ff + NC_W'(1);
                  end else begin
                     check_in = 1'b1;
                  end
               end else begin
                  out_idx_in = '0;
                  state_in   = bfsp_pkg::S_OREAD;
               end
            end else begin
               edge_rd_en = 1'b1;
               state_in   = bfsp_pkg::S_DREAD;
            end
         end

         bfsp_pkg::S_DREAD: begin
            dist_rd_en = 1'b1;
            state_in   = bfsp_pkg::S_CALC;
         end

         bfsp_pkg::S_CALC: begin
            // saturating candidate distance
            if (sum_wide[DIST_W] != sum_wide[DIST_W-1]) begin
               cand_in = sum_wide[DIST_W] ? bfsp_pkg::INT_MIN : bfsp_pkg::INT_MAX;
            end else begin
               cand_in = sum_wide[DIST_W-1:0];
            end
            state_in = bfsp_pkg::S_UPD;
         end

         bfsp_pkg::S_UPD: begin
            k_in     = k_ff + COUNT_W'(1);
            state_in = bfsp_pkg::S_EREAD;
            if (relax_ok) begin
               if (check_ff) begin
                  // still relaxable: negative cycle
                  rsp_valid_in     = 1'b1;
                  rsp_node_in      = '0;
                  rsp_distance_in  = '0;
                  rsp_reachable_in = 1'b0;
                  rsp_cycle_in     = 1'b1;
                  rsp_dropped_in   = dropped_ff;
                  rsp_last_in      = 1'b1;
                  edge_count_in    = '0;
                  dropped_in       = 1'b0;
                  state_in         = bfsp_pkg::S_IDLE;
               end else begin
                  dist_wr_en = 1'b1;
                  reached_in[edge_q.dst[NODE_AW-1:0]] = 1'b1;
               end
            end
         end

         bfsp_pkg::S_OREAD: begin
            dist_rd_en  = 1'b1;
            dist_a_addr = out_idx_ff[NODE_AW-1:0];
            state_in    = bfsp_pkg::S_OEMIT;
         end

         bfsp_pkg::S_OEMIT: begin
            // one result per node
            rsp_valid_in     = 1'b1;
            rsp_node_in      = out_idx_ff[bfsp_pkg::NODE_W-1:0];
            rsp_reachable_in = reached_ff[out_idx_ff[NODE_AW-1:0]];
            rsp_distance_in  = reached_ff[out_idx_ff[NODE_AW-1:0]] ? dist_a : '0;
            rsp_cycle_in     = 1'b0;
            rsp_dropped_in   = dropped_ff;
            rsp_last_in      = (out_idx_ff + NC_W'(1)) == n_eff;
            if ((out_idx_ff + NC_W'(1)) == n_eff) begin
               edge_count_in = '0;
               dropped_in    = 1'b0;
               state_in      = bfsp_pkg::S_IDLE;
            end else begin
               out_idx_in = out_idx_ff + NC_W'(1);
               state_in   = bfsp_pkg::S_OREAD;
            end
         end

         default: begin
            state_in = bfsp_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bfsp_pkg::S_IDLE;
         edge_count_ff <= '0;
         k_ff          <= '0;
         pass_ff       <= '0;
         check_ff      <= 1'b0;
         dropped_ff    <= 1'b0;
         out_idx_ff    <= '0;
         reached_ff    <= '0;
         node_count_ff <= bfsp_pkg::NC_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         k_ff          <= k_in;
         pass_ff       <= pass_in;
         check_ff      <= check_in;
         dropped_ff    <= dropped_in;
         out_idx_ff    <= out_idx_in;
         reached_ff    <= reached_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cand_ff          <= cand_in;
      rsp_node_ff      <= rsp_node_in;
      rsp_distance_ff  <= rsp_distance_in;
      rsp_reachable_ff <= rsp_reachable_in;
      rsp_cycle_ff     <= rsp_cycle_in;
      rsp_dropped_ff   <= rsp_dropped_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign busy               = (state_ff != bfsp_pkg::S_IDLE);
   assign csr_ready          = 1'b1;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_node           = rsp_node_ff;
   assign rsp_distance       = rsp_distance_ff;
   assign rsp_reachable      = rsp_reachable_ff;
   assign rsp_negative_cycle = rsp_cycle_ff;
   assign rsp_edges_dropped  = rsp_dropped_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

/* tb/shortest_path_check.sv */
`timescale 1ns / 1ps

module shortest_path_check (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic                                  req_action,
   input  logic [bfsp_pkg::NODE_W-1:0]           req_edge_from,
   input  logic [bfsp_pkg::NODE_W-1:0]           req_edge_to,
   input  logic signed [bfsp_pkg::WEIGHT_W-1:0]  req_edge_weight,
   input  logic                                  rsp_valid,
   input  logic [bfsp_pkg::NODE_W-1:0]           rsp_node,
   input  logic signed [bfsp_pkg::DIST_W-1:0]    rsp_distance,
   input  logic                                  rsp_reachable,
   input  logic                                  rsp_negative_cycle,
   input  logic                                  rsp_edges_dropped,
   input  logic                                  rsp_last,
   input  logic                                  csr_valid,
   input  logic                                  csr_ready,
   input  logic [bfsp_pkg::NC_W-1:0]             csr_node_count,
   output int                                    fail_count,
   output int                                    pending
);

   import bfsp_pkg::*;

   localparam int REPORT_DEPTH = 2 * MAX_NODES;

   typedef struct packed {
      logic [NODE_W-1:0]        node;
      logic signed [DIST_W-1:0] distance;
      logic                     reachable;
      logic                     negative_cycle;
      logic                     edges_dropped;
      logic                     last;
   } node_report_type;

   // mirror of the graph held by the block
   logic [NODE_W-1:0]          graph_src [MAX_EDGES];
   logic [NODE_W-1:0]          graph_dst [MAX_EDGES];
   logic signed [WEIGHT_W-1:0] graph_wt  [MAX_EDGES];
   int unsigned                graph_edges;
   logic                       graph_dropped;
   logic [NC_W-1:0]            node_limit;

   // working distances of one run
   logic signed [DIST_W-1:0]   best_dist [MAX_NODES];
   logic                       reached   [MAX_NODES];

   // expected results in order, kept in a ring
   node_report_type            report_buf [REPORT_DEPTH];
   int unsigned                report_head;
   int unsigned                report_tail;
   int unsigned                report_count;
   node_report_type            want;
   int                         mismatch_count;

   function automatic int unsigned live_nodes();
      if (node_limit == 0) return 1;
      if (node_limit > NC_MAX) return MAX_NODES;
      return node_limit;
   endfunction

   // append one expected result
   function automatic void queue_report(node_report_type r);
      report_buf[report_tail] = r;
      report_tail = (report_tail + 1 == REPORT_DEPTH) ? 0 : report_tail + 1;
      report_count++;
   endfunction

   // 32-bit signed sum that clamps instead of wrapping
   function automatic logic signed [DIST_W-1:0] clamp_sum(logic signed [DIST_W-1:0] a,
                                                          logic signed [WEIGHT_W-1:0] b);
      longint s;
      s = longint'(a) + longint'(b);
      if (s > longint'(INT_MAX)) return INT_MAX;
      if (s < longint'(INT_MIN)) return INT_MIN;
      return DIST_W'(s);
   endfunction

   // one edge relaxation; with apply low it only tells if the edge still improves
   function automatic bit relax_edge(int unsigned k, int unsigned n, bit apply);
      int unsigned              a;
      int unsigned              b;
      logic signed [DIST_W-1:0] cand;
      a = graph_src[k];
      b = graph_dst[k];
      if (a >= n || b >= n) return 0;
      if (!reached[a]) return 0;
      cand = clamp_sum(best_dist[a], graph_wt[k]);
      if (reached[b] && !(cand < best_dist[b])) return 0;
      if (apply) begin
         best_dist[b] = cand;
         reached[b]   = 1'b1;
      end
      return 1;
   endfunction

   // full shortest path run from node 0, queues the reports it produces
   function automatic void solve_paths();
      int unsigned     n;
      int unsigned     i;
      int unsigned     k;
      bit              cycle_found;
      node_report_type r;
      n = live_nodes();
      cycle_found = 0;
      for (i = 0; i < MAX_NODES; i++) begin
         best_dist[i] = '0;
         reached[i]   = 1'b0;
      end
      reached[0] = 1'b1;
      for (i = 1; i < n; i++)
         for (k = 0; k < graph_edges; k++)
            void'(relax_edge(k, n, 1'b1));
      for (k = 0; k < graph_edges && !cycle_found; k++)
         if (relax_edge(k, n, 1'b0)) cycle_found = 1;
      if (cycle_found) begin
         r.node           = '0;
         r.distance       = '0;
         r.reachable      = 1'b0;
         r.negative_cycle = 1'b1;
         r.edges_dropped  = graph_dropped;
         r.last           = 1'b1;
         queue_report(r);
      end else begin
         for (i = 0; i < n; i++) begin
            r.node           = NODE_W'(i);
            r.distance       = reached[i] ? best_dist[i] : '0;
            r.reachable      = reached[i];
            r.negative_cycle = 1'b0;
            r.edges_dropped  = graph_dropped;
            r.last           = (i + 1 == n);
            queue_report(r);
         end
      end
      graph_edges   = 0;
      graph_dropped = 1'b0;
   endfunction

   function automatic void check_field(int unsigned node, string label,
                                       logic signed [63:0] exp_val,
                                       logic signed [63:0] act_val);
      if (exp_val !== act_val) begin
         mismatch_count++;
         $display("%0t: node %0d %s mismatch, expected %0d, actual %0d",
                  $time, node, label, exp_val, act_val);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         graph_edges   = 0;
         graph_dropped = 1'b0;
         node_limit    = NC_RESET;
         report_head   = 0;
         report_tail   = 0;
         report_count  = 0;
      end else begin
         // result transactions belong to runs accepted earlier
         if (rsp_valid) begin
            if (report_count == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result, expected none, actual node %0d",
                        $time, rsp_node);
            end else begin
               want = report_buf[report_head];
               report_head = (report_head + 1 == REPORT_DEPTH) ? 0 : report_head + 1;
               report_count--;
               check_field(want.node, "node", want.node, rsp_node);
               check_field(want.node, "distance", want.distance, rsp_distance);
               check_field(want.node, "reachable", want.reachable, rsp_reachable);
               check_field(want.node, "negative_cycle", want.negative_cycle,
                           rsp_negative_cycle);
               check_field(want.node, "edges_dropped", want.edges_dropped,
                           rsp_edges_dropped);
               check_field(want.node, "last", want.last, rsp_last);
            end
         end
         // register write transaction
         if (csr_valid && csr_ready) node_limit = csr_node_count;
         // request transaction
         if (start && !busy) begin
            if (req_action == ACT_RUN) begin
               solve_paths();
            end else if (graph_edges >= MAX_EDGES || req_edge_from >= live_nodes()
                         || req_edge_to >= live_nodes()) begin
               graph_dropped = 1'b1;
            end else begin
               graph_src[graph_edges] = req_edge_from;
               graph_dst[graph_edges] = req_edge_to;
               graph_wt[graph_edges]  = req_edge_weight;
               graph_edges++;
            end
         end
      end
      fail_count <= mismatch_count;
      pending    <= int'(report_count);
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

   import bfsp_pkg::*;

   logic                       clock;
   logic                       reset;
   logic                       start;
   logic                       busy;
   logic                       req_action;
   logic [NODE_W-1:0]          req_edge_from;
   logic [NODE_W-1:0]          req_edge_to;
   logic signed [WEIGHT_W-1:0] req_edge_weight;
   logic                       rsp_valid;
   logic [NODE_W-1:0]          rsp_node;
   logic signed [DIST_W-1:0]   rsp_distance;
   logic                       rsp_reachable;
   logic                       rsp_negative_cycle;
   logic                       rsp_edges_dropped;
   logic                       rsp_last;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [NC_W-1:0]            csr_node_count;

   int                         fail_count;
   int                         pending;
   int unsigned                idle_pct;
   int unsigned                items_sent;
   int unsigned                phase_start;
   int unsigned                guard;
   int unsigned                phase;
   int unsigned                idle_plan [3];
   logic [NC_W-1:0]            cur_nc;

   bellman_ford_shortest_paths dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_edge_from      (req_edge_from),
      .req_edge_to        (req_edge_to),
      .req_edge_weight    (req_edge_weight),
      .rsp_valid          (rsp_valid),
      .rsp_node           (rsp_node),
      .rsp_distance       (rsp_distance),
      .rsp_reachable      (rsp_reachable),
      .rsp_negative_cycle (rsp_negative_cycle),
      .rsp_edges_dropped  (rsp_edges_dropped),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_node_count     (csr_node_count)
   );

   shortest_path_check u_path_check (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_action         (req_action),
      .req_edge_from      (req_edge_from),
      .req_edge_to        (req_edge_to),
      .req_edge_weight    (req_edge_weight),
      .rsp_valid          (rsp_valid),
      .rsp_node           (rsp_node),
      .rsp_distance       (rsp_distance),
      .rsp_reachable      (rsp_reachable),
      .rsp_negative_cycle (rsp_negative_cycle),
      .rsp_edges_dropped  (rsp_edges_dropped),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_node_count     (csr_node_count),
      .fail_count         (fail_count),
      .pending            (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("FAILURE");
      $finish;
   end

   // one request transaction; entered and left at a falling edge
   task automatic send_item(input logic act, input logic [NODE_W-1:0] e_src,
                            input logic [NODE_W-1:0] e_dst,
                            input logic signed [WEIGHT_W-1:0] e_wt);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start           <= 1'b1;
      req_action      <= act;
      req_edge_from   <= e_src;
      req_edge_to     <= e_dst;
      req_edge_weight <= e_wt;
      do @(posedge clock); while (busy);
      items_sent++;
      @(negedge clock);
   endtask

   // register write once nothing is in flight
   task automatic set_node_count(input logic [NC_W-1:0] nc);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_valid      <= 1'b1;
      csr_node_count <= nc;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_nc = nc;
   endtask

   // random graph: optional new node count, a batch of edge loads, then a run
   task automatic random_graph();
      int unsigned                pick;
      int unsigned                n_eff;
      int unsigned                n_edges;
      int unsigned                k;
      logic [NODE_W-1:0]          a;
      logic [NODE_W-1:0]          b;
      logic signed [WEIGHT_W-1:0] w;
      if ($urandom_range(99) < 70) begin
         pick = $urandom_range(99);
         if (pick < 5)       set_node_count(NC_W'(0));
         else if (pick < 10) set_node_count(NC_W'(1));
         else if (pick < 15) set_node_count(NC_W'(MAX_NODES));
         else if (pick < 19) set_node_count(NC_W'($urandom_range(65, 127)));
         else if (pick < 30) set_node_count(NC_W'($urandom_range(9, 40)));
         else                set_node_count(NC_W'($urandom_range(2, 8)));
      end
      n_eff = (cur_nc == 0) ? 1 : ((cur_nc > MAX_NODES) ? MAX_NODES : cur_nc);
      n_edges = (n_eff > 16) ? $urandom_range(10) : $urandom_range(16);
      for (k = 0; k < n_edges; k++) begin
         a = ($urandom_range(99) < 30) ? '0 : NODE_W'($urandom_range(n_eff - 1));
         b = NODE_W'($urandom_range(n_eff - 1));
         // occasionally any endpoint, often outside the graph
         if ($urandom_range(99) < 12) begin
            a = NODE_W'($urandom);
            b = NODE_W'($urandom);
         end
         pick = $urandom_range(99);
         if (pick < 4)       w = 16'sh7fff;
         else if (pick < 8)  w = 16'sh8000;
         else if (pick < 12) w = '0;
         else if (pick < 27) begin
            w = WEIGHT_W'($urandom_range(1, 40));
            w = -w;
         end
         else if (pick < 42) w = WEIGHT_W'($urandom);
         else                w = WEIGHT_W'($urandom_range(100));
         send_item(ACT_LOAD, a, b, w);
      end
      // shrink the graph after loading now and then
      if (n_eff > 1 && $urandom_range(99) < 15)
         set_node_count(NC_W'($urandom_range(1, n_eff - 1)));
      send_item(ACT_RUN, NODE_W'($urandom), NODE_W'($urandom), WEIGHT_W'($urandom));
   endtask

   initial begin
      reset           = 1'b1;
      start           = 1'b0;
      req_action      = ACT_LOAD;
      req_edge_from   = '0;
      req_edge_to     = '0;
      req_edge_weight = '0;
      csr_valid       = 1'b0;
      csr_node_count  = '0;
      cur_nc          = NC_RESET;
      idle_pct        = 0;
      items_sent      = 0;
      idle_plan       = '{12, 65, 0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty store at the reset node count
      send_item(ACT_RUN, '0, '0, '0);
      // weight extremes and the highest node
      send_item(ACT_LOAD, 6'd0, 6'd63, 16'sh7fff);
      send_item(ACT_LOAD, 6'd63, 6'd1, 16'sh8000);
      send_item(ACT_LOAD, 6'd1, 6'd2, '0);
      send_item(ACT_RUN, '0, '0, '0);
      // negative cycle between nodes 1 and 2, plus a dropped edge
      set_node_count(NC_W'(3));
      send_item(ACT_LOAD, 6'd0, 6'd1, 16'sd5);
      send_item(ACT_LOAD, 6'd1, 6'd2, -16'sd3);
      send_item(ACT_LOAD, 6'd2, 6'd1, -16'sd3);
      send_item(ACT_LOAD, 6'd0, 6'd63, 16'sd7);
      send_item(ACT_RUN, '0, '0, '0);
      // zero node count acts as one; negative self loop on the source
      set_node_count(NC_W'(0));
      send_item(ACT_LOAD, 6'd0, 6'd0, -16'sd1);
      send_item(ACT_LOAD, 6'd0, 6'd1, 16'sd1);
      send_item(ACT_RUN, '0, '0, '0);
      // node count above the maximum, edge out of reach of the source
      set_node_count(NC_W'(127));
      send_item(ACT_LOAD, 6'd5, 6'd6, 16'sd100);
      send_item(ACT_LOAD, 6'd0, 6'd2, 16'sh8000);
      send_item(ACT_RUN, '0, '0, '0);
      // node count lowered between loading and the run
      set_node_count(NC_W'(8));
      send_item(ACT_LOAD, 6'd0, 6'd7, 16'sd10);
      send_item(ACT_LOAD, 6'd7, 6'd3, 16'sd1);
      send_item(ACT_LOAD, 6'd0, 6'd3, 16'sd20);
      set_node_count(NC_W'(4));
      send_item(ACT_RUN, '0, '0, '0);

      // random graphs under each idling mix
      for (phase = 0; phase < 3; phase++) begin
         idle_pct    = idle_plan[phase];
         phase_start = items_sent;
         while (items_sent - phase_start < 65) random_graph();
      end
      start <= 1'b0;

      // drain outstanding results
      for (guard = 0; guard < 200000 && pending != 0; guard++) @(negedge clock);
      repeat (20) @(negedge clock);
      if (pending != 0)
         $display("%0t: %0d expected results never arrived", $time, pending);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* sim.f */
sv/bfsp_pkg.sv
sv/bfsp_ram.sv
sv/bellman_ford_shortest_paths.sv
tb/shortest_path_check.sv
tb/tb.sv
